@@ rtl/core/gpi_pkg.sv @@
// Shared widths, body record and arithmetic unit request types for the gravity integrator.
package gpi_pkg;

  localparam int DEF_MAX_BODIES = 1024;

  localparam int Q_W        = 32;   // Q16.16 word
  localparam int IDX_W      = 10;   // body slot field
  localparam int BC_W       = 11;   // body_count register
  localparam int MD_W       = 17;   // min_dist_sq register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int DIFF_W  = Q_W + 1;            // separation, signed
  localparam int MUL_A_W = 2 * DIFF_W;         // squared distance, Q32.32
  localparam int MUL_B_W = DIFF_W + 1;         // distance, mass, |separation|
  localparam int MUL_P_W = 100;                // largest product: D * r
  localparam int SQ_IN_W  = MUL_A_W;
  localparam int SQ_OUT_W = MUL_B_W;
  localparam int DIV_W   = MUL_P_W;
  localparam int K_W     = 64;                 // inverse cube distance
  localparam int K_EXP   = 88;                 // numerator is 2^K_EXP
  localparam int T_SHIFT = 24;                 // mass scaling shift
  localparam int DV_SHIFT = 32;                // velocity change shift
  localparam int MAG_W   = DIFF_W;             // velocity change magnitude

  // Input item action codes.
  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_STEP = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // Config register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BODY_COUNT  = 2'd0,
    CFG_MIN_DIST_SQ = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [Q_W-1:0] px;
    logic [Q_W-1:0] py;
    logic [Q_W-1:0] pz;
    logic [Q_W-1:0] vx;
    logic [Q_W-1:0] vy;
    logic [Q_W-1:0] vz;
    logic [Q_W-1:0] m;
  } body_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [SQ_IN_W-1:0] val;
  } sqrt_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] den;
  } div_req_t;

endpackage

@@ rtl/core/gpi_body_ram.sv @@
// Body store: one write port, one registered read port.
module gpi_body_ram #(
  parameter int DEPTH = gpi_pkg::DEF_MAX_BODIES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  gpi_pkg::body_t      wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output gpi_pkg::body_t      rd_data
);

  gpi_pkg::body_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/gpi_serial_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle.
module gpi_serial_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  gpi_pkg::mul_req_t            req,
  output logic                         done,
  output logic [gpi_pkg::MUL_P_W-1:0]  prod
);

  localparam int P     = gpi_pkg::MUL_P_W;
  localparam int B     = gpi_pkg::MUL_B_W;
  localparam int CNT_W = $clog2(B + 1);

  logic [P-1:0]     a_sh;
  logic [B-1:0]     b_sh;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(B);
        prod <= '0;
        a_sh <= P'(req.a);
        b_sh <= req.b;
      end else if (busy) begin
        if (b_sh[0]) begin
          prod <= prod + a_sh;
        end
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/gpi_isqrt.sv @@
// Integer square root, one result bit per cycle.
module gpi_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  gpi_pkg::sqrt_req_t            req,
  output logic                          done,
  output logic [gpi_pkg::SQ_OUT_W-1:0]  root
);

  localparam int IW    = gpi_pkg::SQ_IN_W;
  localparam int STEPS = IW / 2;
  localparam int RW    = STEPS + 3;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [IW-1:0]    val;
  logic [RW-1:0]    rem;
  logic [STEPS-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;

  assign rem_sh = {rem[RW-3:0], val[IW-1 -: 2]};
  assign trial  = RW'({acc, 2'b01});
  assign root   = gpi_pkg::SQ_OUT_W'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
        val  <= req.val;
        rem  <= '0;
        acc  <= '0;
      end else if (busy) begin
        val <= val << 2;
        if (rem_sh >= trial) begin
          rem <= rem_sh - trial;
          acc <= {acc[STEPS-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          acc <= {acc[STEPS-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/gpi_recip_div.sv @@
// Restoring divider for 2^K_EXP / den, saturating the quotient to K_W bits.
module gpi_recip_div (
  input  logic                     clk,
  input  logic                     rst,
  input  gpi_pkg::div_req_t        req,
  output logic                     done,
  output logic [gpi_pkg::K_W-1:0]  quot
);

  localparam int DW    = gpi_pkg::DIV_W;
  localparam int KW    = gpi_pkg::K_W;
  localparam int KE    = gpi_pkg::K_EXP;
  localparam int CNT_W = $clog2(KE + 1);

  logic [DW-1:0]    den;
  logic [DW-1:0]    rem;
  logic [KW-1:0]    q;
  logic             over;
  logic [CNT_W-1:0] bit_pos;
  logic             busy;
  logic [DW:0]      rem_sh;
  logic             ge;

  assign rem_sh = {rem, bit_pos == CNT_W'(KE)};
  assign ge     = rem_sh >= {1'b0, den};
  assign quot   = over ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_pos <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        bit_pos <= CNT_W'(KE);
        den     <= req.den;
        rem     <= '0;
        q       <= '0;
        over    <= 1'b0;
      end else if (busy) begin
        if (ge) begin
          rem <= DW'(rem_sh - {1'b0, den});
        end else begin
          rem <= DW'(rem_sh);
        end
        q <= {q[KW-2:0], ge};
        if (ge && (bit_pos >= CNT_W'(KW))) begin
          over <= 1'b1;
        end
        bit_pos <= bit_pos - CNT_W'(1);
        if (bit_pos == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/pairwise_gravity_integrator_unit.sv @@
// Top level of the pairwise gravity integrator: sequencer, body store and arithmetic units.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   action, body_index, load_pos_*, load_vel_*, load_mass
//   out      source     out_valid/out_stall out_index, out_pos_*, out_vel_*, saturated
//   cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// A load answers straight from the idle state; a read waits in S_RD_WAIT for the body store
// read port. A step walks every pair of bodies and then updates each position; the serial
// multiplier (twelve products per pair) and the divider set its length. Reset is
// synchronous; it clears the sequencer, out_valid, the saturation flag and the config
// registers, not the body store.
// in_stall is high while an item is in work and while a result waits on a stalled output.
module pairwise_gravity_integrator_unit #(
  parameter int MAX_BODIES = gpi_pkg::DEF_MAX_BODIES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic [gpi_pkg::IDX_W-1:0]        body_index,
  input  logic signed [gpi_pkg::Q_W-1:0]   load_pos_x,
  input  logic signed [gpi_pkg::Q_W-1:0]   load_pos_y,
  input  logic signed [gpi_pkg::Q_W-1:0]   load_pos_z,
  input  logic signed [gpi_pkg::Q_W-1:0]   load_vel_x,
  input  logic signed [gpi_pkg::Q_W-1:0]   load_vel_y,
  input  logic signed [gpi_pkg::Q_W-1:0]   load_vel_z,
  input  logic [gpi_pkg::Q_W-1:0]          load_mass,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gpi_pkg::IDX_W-1:0]        out_index,
  output logic signed [gpi_pkg::Q_W-1:0]   out_pos_x,
  output logic signed [gpi_pkg::Q_W-1:0]   out_pos_y,
  output logic signed [gpi_pkg::Q_W-1:0]   out_pos_z,
  output logic signed [gpi_pkg::Q_W-1:0]   out_vel_x,
  output logic signed [gpi_pkg::Q_W-1:0]   out_vel_y,
  output logic signed [gpi_pkg::Q_W-1:0]   out_vel_z,
  output logic                             saturated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gpi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gpi_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_BODIES);
  localparam int CW = $clog2(MAX_BODIES + 1);
  localparam int QW = gpi_pkg::Q_W;
  localparam int DW = gpi_pkg::DIFF_W;
  localparam int PW = gpi_pkg::MUL_P_W;
  localparam int AWID = gpi_pkg::MUL_A_W;
  localparam int BWID = gpi_pkg::MUL_B_W;
  localparam int KW = gpi_pkg::K_W;
  localparam int TS = gpi_pkg::T_SHIFT;
  localparam int VS = gpi_pkg::DV_SHIFT;
  localparam int MW = gpi_pkg::MAG_W;
  localparam int SW = QW + 4;   // width of a velocity or position sum before clamping
  localparam int LB_SHIFT = 16; // min_dist_sq is scaled up to Q32.32

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_WAIT,
    S_OUTER, S_I_WAIT, S_J_RD, S_J_WAIT,
    S_SQX, S_SQY, S_SQZ, S_CLAMP, S_SQRT, S_DEN, S_DIV, S_TI, S_TJ, S_DV,
    S_WR_J, S_WR_I,
    S_U_RD, S_U_WAIT, S_U_WR,
    S_FIN
  } state_t;

  state_t state;

  // Config registers.
  logic [gpi_pkg::BC_W-1:0] body_count;
  logic [gpi_pkg::MD_W-1:0] min_dist_sq;

  // Step bookkeeping.
  logic                 flag;
  logic [CW-1:0]        n_reg;
  logic [CW-1:0]        i;
  logic [CW-1:0]        j;
  logic [AWID-1:0]      lowb;
  gpi_pkg::body_t       bi;
  gpi_pkg::body_t       bj;
  logic [DW-1:0]        dx;
  logic [DW-1:0]        dy;
  logic [DW-1:0]        dz;
  logic [AWID-1:0]      dsq;
  logic [KW-1:0]        k;
  logic [KW-1:0]        ti;
  logic [KW-1:0]        tj;
  logic [1:0]           ax;
  logic                 side;
  logic                 rd_oob;
  logic [gpi_pkg::IDX_W-1:0] rd_idx;

  // Arithmetic units.
  gpi_pkg::mul_req_t    mul_req;
  gpi_pkg::sqrt_req_t   sqrt_req;
  gpi_pkg::div_req_t    div_req;
  logic                 mul_done;
  logic [PW-1:0]        prod;
  logic                 sqrt_done;
  logic [gpi_pkg::SQ_OUT_W-1:0] root;
  logic                 div_done;
  logic [KW-1:0]        quot;

  // Body store ports.
  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  gpi_pkg::body_t       ram_wr_data;
  logic                 ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  gpi_pkg::body_t       ram_rd_data;

  logic in_xfer;
  logic out_busy;
  logic idx_ok;

  function automatic logic [DW-1:0] abs_d(logic [DW-1:0] d);
    return d[DW-1] ? (~d + DW'(1)) : d;
  endfunction

  // Clamp a sum to the signed word; top bit of the result flags a clamp.
  function automatic logic [QW:0] sat_word(logic [SW-1:0] s);
    logic hi_same;
    hi_same = (s[SW-1:QW-1] == '0) || (s[SW-1:QW-1] == '1);
    if (hi_same) begin
      return {1'b0, s[QW-1:0]};
    end else if (s[SW-1]) begin
      return {1'b1, 1'b1, {(QW-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(QW-1){1'b1}}};
    end
  endfunction

  function automatic logic [SW-1:0] sext_w(logic [QW-1:0] v);
    return {{(SW-QW){v[QW-1]}}, v};
  endfunction

  function automatic logic [QW-1:0] get_v(gpi_pkg::body_t b, logic [1:0] a);
    case (a)
      AX_X:    return b.vx;
      AX_Y:    return b.vy;
      default: return b.vz;
    endcase
  endfunction

  assign in_xfer   = in_valid && !in_stall;
  assign out_busy  = out_valid && out_stall;
  assign in_stall  = (state != S_IDLE) || out_busy;
  assign cfg_ready = 1'b1;
  assign idx_ok    = 32'(body_index) < MAX_BODIES;

  // Separation of the freshly read body j from the held body i.
  logic [DW-1:0] dx_c;
  logic [DW-1:0] dy_c;
  logic [DW-1:0] dz_c;
  assign dx_c = {ram_rd_data.px[QW-1], ram_rd_data.px} - {bi.px[QW-1], bi.px};
  assign dy_c = {ram_rd_data.py[QW-1], ram_rd_data.py} - {bi.py[QW-1], bi.py};
  assign dz_c = {ram_rd_data.pz[QW-1], ram_rd_data.pz} - {bi.pz[QW-1], bi.pz};

  // Velocity change for the current axis and side.
  logic [DW-1:0] d_cur;
  logic [DW-1:0] d_nxt;
  logic [MW:0]   mag;
  logic          neg;
  logic [SW-1:0] dv_w;
  logic [QW:0]   v_res;

  always_comb begin
    case (ax)
      AX_X:    d_cur = dx;
      AX_Y:    d_cur = dy;
      default: d_cur = dz;
    endcase
    case (ax)
      AX_X:    d_nxt = dy;
      default: d_nxt = dz;
    endcase
    if (prod[PW-1:VS+MW] != '0) begin
      mag = {1'b1, {MW{1'b0}}};
    end else begin
      mag = {1'b0, prod[VS+MW-1:VS]};
    end
    neg   = d_cur[DW-1] ^ side;
    dv_w  = neg ? (~SW'(mag) + SW'(1)) : SW'(mag);
    v_res = sat_word(sext_w(get_v(side ? bj : bi, ax)) + dv_w);
  end

  // Position update of the held body.
  logic [QW:0] px_res;
  logic [QW:0] py_res;
  logic [QW:0] pz_res;
  assign px_res = sat_word(sext_w(bi.px) + sext_w(bi.vx));
  assign py_res = sat_word(sext_w(bi.py) + sext_w(bi.vy));
  assign pz_res = sat_word(sext_w(bi.pz) + sext_w(bi.vz));

  // Body store control follows the sequencer state.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = AW'(body_index);
    ram_wr_data = '{px: load_pos_x, py: load_pos_y, pz: load_pos_z,
                    vx: load_vel_x, vy: load_vel_y, vz: load_vel_z, m: load_mass};
    ram_rd_en   = 1'b0;
    ram_rd_addr = AW'(body_index);
    case (state)
      S_IDLE: begin
        ram_wr_en = in_xfer && (action == gpi_pkg::ACT_LOAD) && idx_ok;
        ram_rd_en = in_xfer && (action == gpi_pkg::ACT_READ) && idx_ok;
      end
      S_OUTER: begin
        ram_rd_en   = (i + CW'(1)) < n_reg;
        ram_rd_addr = i[AW-1:0];
      end
      S_J_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = j[AW-1:0];
      end
      S_WR_J: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = j[AW-1:0];
        ram_wr_data = bj;
      end
      S_WR_I: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = i[AW-1:0];
        ram_wr_data = bi;
      end
      S_U_RD: begin
        ram_rd_en   = i < n_reg;
        ram_rd_addr = i[AW-1:0];
      end
      S_U_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = i[AW-1:0];
        ram_wr_data = bi;
        ram_wr_data.px = px_res[QW-1:0];
        ram_wr_data.py = py_res[QW-1:0];
        ram_wr_data.pz = pz_res[QW-1:0];
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  // Config writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      body_count  <= '0;
      min_dist_sq <= gpi_pkg::MD_W'(7);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gpi_pkg::CFG_BODY_COUNT:  body_count  <= cfg_data[gpi_pkg::BC_W-1:0];
        gpi_pkg::CFG_MIN_DIST_SQ: min_dist_sq <= cfg_data[gpi_pkg::MD_W-1:0];
        default:                  ;
      endcase
    end
  end

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      flag      <= 1'b0;
      mul_req   <= '0;
      sqrt_req  <= '0;
      div_req   <= '0;
    end else begin
      mul_req.start  <= 1'b0;
      sqrt_req.start <= 1'b0;
      div_req.start  <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (action)
              gpi_pkg::ACT_STEP: begin
                // Clear the flag, clip the body count and scale the distance clamp.
                flag  <= 1'b0;
                n_reg <= (32'(body_count) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(body_count);
                lowb  <= AWID'({(min_dist_sq == '0) ? gpi_pkg::MD_W'(1) : min_dist_sq,
                                {LB_SHIFT{1'b0}}});
                i     <= '0;
                state <= S_OUTER;
              end
              gpi_pkg::ACT_READ: begin
                rd_idx <= body_index;
                rd_oob <= !idx_ok;
                state  <= S_RD_WAIT;
              end
              default: begin
                // Load and the unused code answer at once with the slot and zeros.
                out_valid <= 1'b1;
                out_index <= body_index;
                out_pos_x <= '0;
                out_pos_y <= '0;
                out_pos_z <= '0;
                out_vel_x <= '0;
                out_vel_y <= '0;
                out_vel_z <= '0;
                saturated <= flag;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          if (!out_busy) begin
            out_valid <= 1'b1;
            out_index <= rd_idx;
            out_pos_x <= rd_oob ? '0 : ram_rd_data.px;
            out_pos_y <= rd_oob ? '0 : ram_rd_data.py;
            out_pos_z <= rd_oob ? '0 : ram_rd_data.pz;
            out_vel_x <= rd_oob ? '0 : ram_rd_data.vx;
            out_vel_y <= rd_oob ? '0 : ram_rd_data.vy;
            out_vel_z <= rd_oob ? '0 : ram_rd_data.vz;
            saturated <= flag;
            state     <= S_IDLE;
          end
        end
        S_OUTER: begin
          if ((i + CW'(1)) < n_reg) begin
            state <= S_I_WAIT;
          end else begin
            i     <= '0;
            state <= S_U_RD;
          end
        end
        S_I_WAIT: begin
          bi    <= ram_rd_data;
          j     <= i + CW'(1);
          state <= S_J_RD;
        end
        S_J_RD: begin
          state <= S_J_WAIT;
        end
        S_J_WAIT: begin
          bj <= ram_rd_data;
          dx <= dx_c;
          dy <= dy_c;
          dz <= dz_c;
          mul_req <= '{start: 1'b1, a: AWID'(abs_d(dx_c)), b: BWID'(abs_d(dx_c))};
          state   <= S_SQX;
        end
        S_SQX: begin
          if (mul_done) begin
            dsq     <= prod[AWID-1:0];
            mul_req <= '{start: 1'b1, a: AWID'(abs_d(dy)), b: BWID'(abs_d(dy))};
            state   <= S_SQY;
          end
        end
        S_SQY: begin
          if (mul_done) begin
            dsq     <= dsq + prod[AWID-1:0];
            mul_req <= '{start: 1'b1, a: AWID'(abs_d(dz)), b: BWID'(abs_d(dz))};
            state   <= S_SQZ;
          end
        end
        S_SQZ: begin
          if (mul_done) begin
            dsq   <= dsq + prod[AWID-1:0];
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          // Raise the squared distance to the clamp.
          if (dsq <= lowb) begin
            dsq          <= lowb;
            sqrt_req.val <= lowb;
          end else begin
            sqrt_req.val <= dsq;
          end
          sqrt_req.start <= 1'b1;
          state          <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_done) begin
            mul_req <= '{start: 1'b1, a: dsq, b: BWID'(root)};
            state   <= S_DEN;
          end
        end
        S_DEN: begin
          if (mul_done) begin
            div_req <= '{start: 1'b1, den: prod};
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            k       <= quot;
            mul_req <= '{start: 1'b1, a: AWID'(quot), b: BWID'(bj.m)};
            state   <= S_TI;
          end
        end
        S_TI: begin
          if (mul_done) begin
            if (prod[PW-1:TS+KW] != '0) begin
              ti   <= '1;
              flag <= 1'b1;
            end else begin
              ti <= prod[TS+KW-1:TS];
            end
            mul_req <= '{start: 1'b1, a: AWID'(k), b: BWID'(bi.m)};
            state   <= S_TJ;
          end
        end
        S_TJ: begin
          if (mul_done) begin
            if (prod[PW-1:TS+KW] != '0) begin
              tj   <= '1;
              flag <= 1'b1;
            end else begin
              tj <= prod[TS+KW-1:TS];
            end
            ax      <= AX_X;
            side    <= 1'b0;
            mul_req <= '{start: 1'b1, a: AWID'(ti), b: BWID'(abs_d(dx))};
            state   <= S_DV;
          end
        end
        S_DV: begin
          if (mul_done) begin
            // Apply to body i along +d, then to body j along -d.
            if (v_res[QW]) begin
              flag <= 1'b1;
            end
            if (side) begin
              case (ax)
                AX_X:    bj.vx <= v_res[QW-1:0];
                AX_Y:    bj.vy <= v_res[QW-1:0];
                default: bj.vz <= v_res[QW-1:0];
              endcase
            end else begin
              case (ax)
                AX_X:    bi.vx <= v_res[QW-1:0];
                AX_Y:    bi.vy <= v_res[QW-1:0];
                default: bi.vz <= v_res[QW-1:0];
              endcase
            end
            if (ax != AX_Z) begin
              ax      <= ax + 2'd1;
              mul_req <= '{start: 1'b1, a: AWID'(side ? tj : ti), b: BWID'(abs_d(d_nxt))};
            end else if (!side) begin
              ax      <= AX_X;
              side    <= 1'b1;
              mul_req <= '{start: 1'b1, a: AWID'(tj), b: BWID'(abs_d(dx))};
            end else begin
              state <= S_WR_J;
            end
          end
        end
        S_WR_J: begin
          j <= j + CW'(1);
          if ((j + CW'(1)) < n_reg) begin
            state <= S_J_RD;
          end else begin
            state <= S_WR_I;
          end
        end
        S_WR_I: begin
          i     <= i + CW'(1);
          state <= S_OUTER;
        end
        S_U_RD: begin
          if (i < n_reg) begin
            state <= S_U_WAIT;
          end else begin
            state <= S_FIN;
          end
        end
        S_U_WAIT: begin
          bi    <= ram_rd_data;
          state <= S_U_WR;
        end
        S_U_WR: begin
          if (px_res[QW] || py_res[QW] || pz_res[QW]) begin
            flag <= 1'b1;
          end
          i     <= i + CW'(1);
          state <= S_U_RD;
        end
        S_FIN: begin
          if (!out_busy) begin
            out_valid <= 1'b1;
            out_index <= '0;
            out_pos_x <= '0;
            out_pos_y <= '0;
            out_pos_z <= '0;
            out_vel_x <= '0;
            out_vel_y <= '0;
            out_vel_z <= '0;
            saturated <= flag;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  gpi_body_ram #(
    .DEPTH (MAX_BODIES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  gpi_serial_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (prod)
  );

  gpi_isqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (sqrt_req),
    .done (sqrt_done),
    .root (root)
  );

  gpi_recip_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (quot)
  );

  // The sequencer never reads the entry it writes in the same cycle.
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
    else $error("body store read and write hit one entry");

  // A product only lands while the sequencer waits for one.
  a_mul_done_waited: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_SQX || state == S_SQY || state == S_SQZ || state == S_DEN ||
                  state == S_TI || state == S_TJ || state == S_DV))
    else $error("multiplier result arrived outside a wait state");

  // Pair reads stay inside the active bodies and above the held body.
  a_pair_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_J_RD) |-> (j < n_reg && i < j))
    else $error("pair index out of range");

  // A step result only leaves after the walk over the bodies is finished.
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (i >= n_reg))
    else $error("step finished before all bodies were updated");

endmodule
